### sv/oets_pkg.sv
// Shared types for the odd-even transposition sorter.
// Command and status bundles between controller and cell row; no dependencies.
package oets_pkg;

   localparam int REQ_BITS = 32;

   typedef struct packed {
      logic load;
      logic pass;
      logic parity;
      logic shift;
   } oets_cmd_type;

   typedef struct packed {
      logic swapped;
   } oets_sts_type;

endpackage

### sv/oets_cells.sv
// Datapath: row of element cells with one compare-exchange per adjacent pair.
// Depends on oets_pkg for the command and status bundles.
module oets_cells import oets_pkg::*; #(
   parameter int MAX_ITEMS  = 64,
   parameter int VALUE_BITS = 32,
   parameter int CNT_W      = $clog2(MAX_ITEMS + 1)
) (
   input  logic                clock,
   input  oets_cmd_type        cmd,
   input  logic [CNT_W-1:0]    count,
   input  logic [REQ_BITS-1:0] load_value,
   output logic [REQ_BITS-1:0] head_value,
   output oets_sts_type        sts
);

   localparam int IDX_W = $clog2(MAX_ITEMS);

   logic signed [VALUE_BITS-1:0]          cell_ff [MAX_ITEMS];
   logic signed [VALUE_BITS-1:0]          cell_in [MAX_ITEMS];
   logic        [MAX_ITEMS-2:0]           swp;
   logic        [VALUE_BITS+REQ_BITS-1:0] load_ext;
   logic        [VALUE_BITS+REQ_BITS-1:0] head_ext;
   logic        [IDX_W-1:0]               wr_idx;

   assign load_ext = {{VALUE_BITS{load_value[REQ_BITS-1]}}, load_value};
   assign head_ext = {{REQ_BITS{cell_ff[0][VALUE_BITS-1]}}, cell_ff[0]};
   assign head_value = head_ext[REQ_BITS-1:0];
   assign wr_idx = count[IDX_W-1:0];

   always_comb begin
      for (int k = 0; k < MAX_ITEMS - 1; k++) begin
         swp[k] = cmd.pass && (k[0] == cmd.parity) && (CNT_W'(k + 1) < count) &&
                  (cell_ff[k] > cell_ff[k+1]);
      end
   end

   assign sts.swapped = |swp;

   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < MAX_ITEMS; i++) begin
            if (wr_idx == IDX_W'(i)) begin
               cell_in[i] = load_ext[VALUE_BITS-1:0];
            end
         end
      end
      if (cmd.shift) begin
         for (int i = 0; i < MAX_ITEMS - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
      for (int k = 0; k < MAX_ITEMS - 1; k++) begin
         if (swp[k]) begin
            cell_in[k]   = cell_ff[k+1];
            cell_in[k+1] = cell_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

### sv/oets_ctrl.sv
// Controller: load, sort-pass and emit sequencing, element count and swap flags.
// Depends on oets_pkg for the command and status bundles.
module oets_ctrl import oets_pkg::*; #(
   parameter int MAX_ITEMS = 64,
   parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_is_last,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_is_final,
   output oets_cmd_type     cmd,
   input  oets_sts_type     sts,
   output logic [CNT_W-1:0] count
);

   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_SORT = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             parity_ff, parity_in;
   logic             prior_ff, prior_in;
   logic             accept;
   logic             take;

   assign req_stall    = (state_ff != S_LOAD);
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = (state_ff == S_EMIT);
   assign take         = rsp_valid && !rsp_stall;
   assign rsp_is_final = (count_ff == CNT_W'(1));
   assign count        = count_ff;

   assign cmd.load   = accept;
   assign cmd.pass   = (state_ff == S_SORT);
   assign cmd.parity = parity_ff;
   assign cmd.shift  = take;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      parity_in = parity_ff;
      prior_in  = prior_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               count_in = count_ff + CNT_W'(1);
               if (req_is_last || (count_in == CNT_W'(MAX_ITEMS))) begin
                  state_in = S_SORT;
               end
            end
         end
         S_SORT: begin
            if (!sts.swapped && !prior_ff) begin
               state_in = S_EMIT;
            end else begin
               prior_in  = sts.swapped;
               parity_in = !parity_ff;
            end
         end
         S_EMIT: begin
            if (take) begin
               count_in = count_ff - CNT_W'(1);
               if (rsp_is_final) begin
                  state_in  = S_LOAD;
                  parity_in = 1'b0;
                  prior_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in  = S_LOAD;
            count_in  = '0;
            parity_in = 1'b0;
            prior_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         count_ff  <= '0;
         parity_ff <= 1'b0;
         prior_ff  <= 1'b1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         parity_ff <= parity_in;
         prior_ff  <= prior_in;
      end
   end

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("emitting with empty list");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (count_ff < CNT_W'(MAX_ITEMS)))
      else $error("store overflow while loading");

   a_sort_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SORT && state_in == S_EMIT) |-> (!sts.swapped && !prior_ff))
      else $error("sort ended before two clean passes");

   a_last_sorts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last) |=> (state_ff == S_SORT))
      else $error("closing request did not start the sort");

endmodule

### sv/odd_even_transposition_sort.sv
// Top level of the odd-even transposition sorter.
// Instantiates oets_ctrl and oets_cells; uses oets_pkg.
//
//   channel  ports                               direction
//   req      req_valid req_stall req_value        in
//            req_is_last
//   rsp      rsp_valid rsp_stall rsp_sorted_value out
//            rsp_is_final
//
// Requests are accepted one per cycle while loading. After the closing request
// (or a full store) the compare-exchange passes over the cell row run one per
// cycle; a list of n elements needs at most n+2 passes. Results then leave one
// per cycle while rsp_stall is low. Requests are stalled from the closing
// request until the last result is taken. Reset is synchronous; the store
// needs no clearing. A stalled result holds its value until taken.
module odd_even_transposition_sort import oets_pkg::*; #(
   parameter int MAX_ITEMS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [REQ_BITS-1:0] req_value,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [REQ_BITS-1:0] rsp_sorted_value,
   output logic                rsp_is_final
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   oets_cmd_type     cmd;
   oets_sts_type     sts;
   logic [CNT_W-1:0] count;

   oets_ctrl #(
      .MAX_ITEMS (MAX_ITEMS),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_last  (req_is_last),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_final (rsp_is_final),
      .cmd          (cmd),
      .sts          (sts),
      .count        (count)
   );

   oets_cells #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
   ) u_cells (
      .clock      (clock),
      .cmd        (cmd),
      .count      (count),
      .load_value (req_value),
      .head_value (rsp_sorted_value),
      .sts        (sts)
   );

endmodule
